FILE: design/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared widths, register indexes, sequencer step codes and the
// controller/datapath interface types of the best subtarget selector.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int PosW  = 16;
  localparam int VelW  = 15;
  localparam int EtaW  = 16;
  localparam int ViolW = 8;
  localparam int AgeW  = 16;
  localparam int ImpW  = 12;
  localparam int CfgW  = 16;
  localparam int CfgIdxW = 2;

  localparam int AbsW  = 17;              // |pos + vel/2 - target|
  localparam int DistW = 34;              // dx^2 + dy^2
  localparam int M2W   = 2 * ImpW;        // m^2
  localparam int RhsW  = DistW + M2W;     // m^2 * Dc
  localparam int TW    = DistW + 2;       // Db - Dc - m^2, signed
  localparam int SqW   = 64;              // T^2 for T < 2^32
  localparam int MulAW = 34;
  localparam int MulBW = 32;
  localparam int ProdW = MulAW + MulBW;

  localparam logic [CfgIdxW-1:0] REG_TARGET_X   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_Y   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ETA_MARGIN = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_IMPROVE    = 2'd3;

  localparam int StepW = 3;
  localparam logic [StepW-1:0] STEP_DC_X = 3'd0;
  localparam logic [StepW-1:0] STEP_DC_Y = 3'd1;
  localparam logic [StepW-1:0] STEP_DB_X = 3'd2;
  localparam logic [StepW-1:0] STEP_DB_Y = 3'd3;
  localparam logic [StepW-1:0] STEP_M2   = 3'd4;
  localparam logic [StepW-1:0] STEP_RHS  = 3'd5;
  localparam logic [StepW-1:0] STEP_SQ   = 3'd6;
  localparam logic [StepW-1:0] STEP_DEC  = 3'd7;

  typedef struct packed {
    logic             cap;
    logic             step_en;
    logic [StepW-1:0] step;
    logic             commit;
  } bss_cmd_t;

  typedef struct packed {
    logic need_cmp;
  } bss_status_t;

endpackage

FILE: design/bss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller: accepts a word, walks the compare sequence when the best
// must be beaten by distance, and commits into the output register.
// ----------------------------------------------------------------------------
module bss_ctrl
  import bss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  bss_status_t status,
  output bss_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, commit;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = STEP_DC_X;
        if (accept) begin
          state_nxt = status.need_cmp ? ST_CALC : ST_FIN;
        end
      end
      ST_CALC: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_DEC) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = commit || (out_valid_r && !out_ready);

  always_comb begin
    cmd.cap     = accept;
    cmd.step_en = (state_r == ST_CALC);
    cmd.step    = step_r;
    cmd.commit  = commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_DC_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/bss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_dp
// Datapath: configuration, best subtarget, captured candidate, one shared
// multiplier for the exact squared distance test, and the output register.
// ----------------------------------------------------------------------------
module bss_dp
  import bss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]        cfg_wdata,
  input  logic                   in_op,
  input  logic signed [PosW-1:0] in_cand_x,
  input  logic signed [PosW-1:0] in_cand_y,
  input  logic signed [VelW-1:0] in_cand_vx,
  input  logic signed [VelW-1:0] in_cand_vy,
  input  logic [EtaW-1:0]        in_cand_eta,
  input  logic [ViolW-1:0]       in_cand_violations,
  input  logic                   in_cand_clear,
  input  logic [AgeW-1:0]        in_cand_age,
  input  bss_cmd_t               cmd,
  output bss_status_t            status,
  output logic                   out_replaced,
  output logic signed [PosW-1:0] out_best_x_out,
  output logic signed [PosW-1:0] out_best_y_out,
  output logic signed [VelW-1:0] out_best_vx_out,
  output logic signed [VelW-1:0] out_best_vy_out,
  output logic [EtaW-1:0]        out_best_eta_out,
  output logic [ViolW-1:0]       out_best_violations_out,
  output logic                   out_best_clear_out,
  output logic [AgeW-1:0]        out_best_age_out
);

  function automatic logic [AbsW-1:0] axis_abs(
    input logic [PosW-1:0] p,
    input logic [VelW-1:0] v,
    input logic [PosW-1:0] t
  );
    logic [AbsW:0] d;
    logic [AbsW:0] m;
    d = {{2{p[PosW-1]}}, p} + {{4{v[VelW-1]}}, v[VelW-1:1]} - {{2{t[PosW-1]}}, t};
    m = d[AbsW] ? ((AbsW+1)'(0) - d) : d;
    return m[AbsW-1:0];
  endfunction

  // configuration
  logic signed [PosW-1:0] target_x_r, target_y_r;
  logic [EtaW-1:0]        eta_limit_r;
  logic [ImpW-1:0]        improve_r;

  // best subtarget
  logic signed [PosW-1:0] best_x_r, best_y_r;
  logic signed [VelW-1:0] best_vx_r, best_vy_r;
  logic [EtaW-1:0]        best_eta_r;
  logic [ViolW-1:0]       best_viol_r;
  logic                   best_clear_r;
  logic [AgeW-1:0]        best_age_r;

  // captured candidate
  logic signed [PosW-1:0] c_x_r, c_y_r;
  logic signed [VelW-1:0] c_vx_r, c_vy_r;
  logic [EtaW-1:0]        c_eta_r;
  logic [ViolW-1:0]       c_viol_r;
  logic                   c_clear_r;
  logic [AgeW-1:0]        c_age_r;
  logic                   take_r;
  logic                   viol_ok_r;

  // distance test
  logic [AbsW-1:0]  dcx_r, dcy_r, dbx_r, dby_r;
  logic [DistW-1:0] dc_r, db_r;
  logic [M2W-1:0]   m2_r;
  logic [RhsW-1:0]  rhs_r;
  logic [TW-1:0]    t_r;
  logic [SqW-1:0]   sq_r;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [TW-1:0]    t_nxt;
  logic             t_pos, t_big, win;

  assign status.need_cmp = in_op && in_cand_clear && best_clear_r
                           && (best_eta_r > eta_limit_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_DC_X: begin
        mul_a = MulAW'(dcx_r);
        mul_b = MulBW'(dcx_r);
      end
      STEP_DC_Y: begin
        mul_a = MulAW'(dcy_r);
        mul_b = MulBW'(dcy_r);
      end
      STEP_DB_X: begin
        mul_a = MulAW'(dbx_r);
        mul_b = MulBW'(dbx_r);
      end
      STEP_DB_Y: begin
        mul_a = MulAW'(dby_r);
        mul_b = MulBW'(dby_r);
      end
      STEP_M2: begin
        mul_a = MulAW'(improve_r);
        mul_b = MulBW'(improve_r);
      end
      STEP_RHS: begin
        mul_a = dc_r;
        mul_b = MulBW'(m2_r);
      end
      STEP_SQ: begin
        mul_a = MulAW'(t_r[31:0]);
        mul_b = t_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
  assign t_nxt = {2'b00, db_r} - {2'b00, dc_r} - TW'(m2_r);
  assign t_pos = !t_r[TW-1] && (t_r != '0);
  assign t_big = |t_r[TW-2:32];
  assign win   = viol_ok_r && t_pos && (t_big || (sq_r > {4'b0000, rhs_r, 2'b00}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r  <= '0;
      target_y_r  <= '0;
      eta_limit_r <= EtaW'(500);
      improve_r   <= ImpW'(500);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_X:   target_x_r  <= cfg_wdata[PosW-1:0];
        REG_TARGET_Y:   target_y_r  <= cfg_wdata[PosW-1:0];
        REG_ETA_MARGIN: eta_limit_r <= cfg_wdata[EtaW-1:0];
        REG_IMPROVE:    improve_r   <= cfg_wdata[ImpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_x_r     <= '0;
      best_y_r     <= '0;
      best_vx_r    <= '0;
      best_vy_r    <= '0;
      best_eta_r   <= '0;
      best_viol_r  <= '0;
      best_clear_r <= 1'b0;
      best_age_r   <= '0;
    end else if (cmd.commit && take_r) begin
      best_x_r     <= c_x_r;
      best_y_r     <= c_y_r;
      best_vx_r    <= c_vx_r;
      best_vy_r    <= c_vy_r;
      best_eta_r   <= c_eta_r;
      best_viol_r  <= c_viol_r;
      best_clear_r <= c_clear_r;
      best_age_r   <= c_age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      c_x_r     <= in_cand_x;
      c_y_r     <= in_cand_y;
      c_vx_r    <= in_cand_vx;
      c_vy_r    <= in_cand_vy;
      c_eta_r   <= in_cand_eta;
      c_viol_r  <= in_cand_violations;
      c_clear_r <= in_cand_clear;
      c_age_r   <= in_op ? '0 : in_cand_age;
      take_r    <= !in_op || (in_cand_clear && !status.need_cmp);
      viol_ok_r <= (in_cand_violations <= best_viol_r);
      dcx_r     <= axis_abs(in_cand_x, in_cand_vx, target_x_r);
      dcy_r     <= axis_abs(in_cand_y, in_cand_vy, target_y_r);
      dbx_r     <= axis_abs(best_x_r, best_vx_r, target_x_r);
      dby_r     <= axis_abs(best_y_r, best_vy_r, target_y_r);
    end else if (cmd.step_en) begin
      case (cmd.step)
        STEP_DC_X: dc_r  <= prod[DistW-1:0];
        STEP_DC_Y: dc_r  <= dc_r + prod[DistW-1:0];
        STEP_DB_X: db_r  <= prod[DistW-1:0];
        STEP_DB_Y: db_r  <= db_r + prod[DistW-1:0];
        STEP_M2:   m2_r  <= prod[M2W-1:0];
        STEP_RHS: begin
          rhs_r <= prod[RhsW-1:0];
          t_r   <= t_nxt;
        end
        STEP_SQ:   sq_r  <= prod[SqW-1:0];
        STEP_DEC:  take_r <= win;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_replaced <= take_r;
      if (take_r) begin
        out_best_x_out          <= c_x_r;
        out_best_y_out          <= c_y_r;
        out_best_vx_out         <= c_vx_r;
        out_best_vy_out         <= c_vy_r;
        out_best_eta_out        <= c_eta_r;
        out_best_violations_out <= c_viol_r;
        out_best_clear_out      <= c_clear_r;
        out_best_age_out        <= c_age_r;
      end else begin
        out_best_x_out          <= best_x_r;
        out_best_y_out          <= best_y_r;
        out_best_vx_out         <= best_vx_r;
        out_best_vy_out         <= best_vy_r;
        out_best_eta_out        <= best_eta_r;
        out_best_violations_out <= best_viol_r;
        out_best_clear_out      <= best_clear_r;
        out_best_age_out        <= best_age_r;
      end
    end
  end

endmodule

FILE: design/best_subtarget_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_subtarget_selector
// Keeps the best motion subtarget and updates it from load and offer words.
//
//   channel  ports                      handshake
//   in       in_op, in_cand_*           in_valid / in_ready
//   out      out_replaced, out_best_*   out_valid / out_ready
//   cfg      cfg_index, cfg_wdata       cfg_we, no wait
//
// A load, a blocked offer or an offer that replaces without comparison goes
// from accept straight to the finish state and is committed to the output
// register once that register is free; an offer that must beat the best by
// distance first walks seven passes through the one shared multiplier and a
// decision step. One word is in work at a time; a new word is accepted while
// a finished word waits at the output, and a stalled output holds the next
// finished word. Synchronous active-low reset sets the best to zero, not
// collision-free, and the configuration to its defaults.
// ----------------------------------------------------------------------------
module best_subtarget_selector
  import bss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]        cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic signed [PosW-1:0] in_cand_x,
  input  logic signed [PosW-1:0] in_cand_y,
  input  logic signed [VelW-1:0] in_cand_vx,
  input  logic signed [VelW-1:0] in_cand_vy,
  input  logic [EtaW-1:0]        in_cand_eta,
  input  logic [ViolW-1:0]       in_cand_violations,
  input  logic                   in_cand_clear,
  input  logic [AgeW-1:0]        in_cand_age,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_replaced,
  output logic signed [PosW-1:0] out_best_x_out,
  output logic signed [PosW-1:0] out_best_y_out,
  output logic signed [VelW-1:0] out_best_vx_out,
  output logic signed [VelW-1:0] out_best_vy_out,
  output logic [EtaW-1:0]        out_best_eta_out,
  output logic [ViolW-1:0]       out_best_violations_out,
  output logic                   out_best_clear_out,
  output logic [AgeW-1:0]        out_best_age_out
);

  bss_cmd_t    cmd;
  bss_status_t status;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bss_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_op                   (in_op),
    .in_cand_x               (in_cand_x),
    .in_cand_y               (in_cand_y),
    .in_cand_vx              (in_cand_vx),
    .in_cand_vy              (in_cand_vy),
    .in_cand_eta             (in_cand_eta),
    .in_cand_violations      (in_cand_violations),
    .in_cand_clear           (in_cand_clear),
    .in_cand_age             (in_cand_age),
    .cmd                     (cmd),
    .status                  (status),
    .out_replaced            (out_replaced),
    .out_best_x_out          (out_best_x_out),
    .out_best_y_out          (out_best_y_out),
    .out_best_vx_out         (out_best_vx_out),
    .out_best_vy_out         (out_best_vy_out),
    .out_best_eta_out        (out_best_eta_out),
    .out_best_violations_out (out_best_violations_out),
    .out_best_clear_out      (out_best_clear_out),
    .out_best_age_out        (out_best_age_out)
  );

endmodule

FILE: design/bss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks of the best subtarget selector, bound to the top level.
// ----------------------------------------------------------------------------
module bss_checker
  import bss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_op,
  input logic signed [PosW-1:0] in_cand_x,
  input logic                   in_cand_clear,
  input logic [AgeW-1:0]        in_cand_age,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_replaced,
  input logic signed [PosW-1:0] out_best_x_out,
  input logic [AgeW-1:0]        out_best_age_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_x_out)
      && $stable(out_replaced))
    else $error("output word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op && !out_valid |=> ##1
      out_valid && out_replaced && (out_best_x_out == $past(in_cand_x, 2))
      && (out_best_age_out == $past(in_cand_age, 2)))
    else $error("load word not reflected as the new best");

  a_blocked_offer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op && !in_cand_clear && !out_valid |=> ##1
      out_valid && !out_replaced)
    else $error("blocked offer replaced the best");

endmodule

bind best_subtarget_selector bss_checker u_bss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_op            (in_op),
  .in_cand_x        (in_cand_x),
  .in_cand_clear    (in_cand_clear),
  .in_cand_age      (in_cand_age),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_replaced     (out_replaced),
  .out_best_x_out   (out_best_x_out),
  .out_best_age_out (out_best_age_out)
);

FILE: dv/best_subtarget_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_subtarget_selector_tb
// Self-checking bench for the best subtarget selector. A clocked driver
// offers load and offer words from a queue, a local model predicts the
// replaced flag and the best subtarget after each word, and a clocked
// monitor checks every result word field by field. The run steps through
// six register settings, including the extremes, with random idling on
// both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module best_subtarget_selector_tb;
  import bss_pkg::*;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_OFFER = 1'b1;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LIMIT_NS       = 10_000_000;

  typedef struct {
    logic signed [PosW-1:0] x, y;
    logic signed [VelW-1:0] vx, vy;
    logic [EtaW-1:0]        eta;
    logic [ViolW-1:0]       viol;
    logic                   clear;
    logic [AgeW-1:0]        age;
  } subtarget_t;

  typedef struct {
    logic       op;
    subtarget_t c;
  } word_t;

  typedef struct {
    logic       replaced;
    subtarget_t best;
  } sel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic signed [PosW-1:0] in_cand_x = '0;
  logic signed [PosW-1:0] in_cand_y = '0;
  logic signed [VelW-1:0] in_cand_vx = '0;
  logic signed [VelW-1:0] in_cand_vy = '0;
  logic [EtaW-1:0] in_cand_eta = '0;
  logic [ViolW-1:0] in_cand_violations = '0;
  logic in_cand_clear = 1'b0;
  logic [AgeW-1:0] in_cand_age = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_replaced;
  logic signed [PosW-1:0] out_best_x_out;
  logic signed [PosW-1:0] out_best_y_out;
  logic signed [VelW-1:0] out_best_vx_out;
  logic signed [VelW-1:0] out_best_vy_out;
  logic [EtaW-1:0] out_best_eta_out;
  logic [ViolW-1:0] out_best_violations_out;
  logic out_best_clear_out;
  logic [AgeW-1:0] out_best_age_out;

  best_subtarget_selector dut (.*);

  // model state and register copies
  subtarget_t best_now;
  logic signed [PosW-1:0] tgt_x = '0;
  logic signed [PosW-1:0] tgt_y = '0;
  logic [EtaW-1:0] eta_limit = EtaW'(500);
  logic [ImpW-1:0] improve_mm = ImpW'(500);

  word_t word_q[$];
  word_t word_on_bus;
  sel_result_t sel_exp_q[$];
  sel_result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic rx_hold = 1'b0;
  logic hold_kick = 1'b0;

  int n_words = 0, n_loads = 0, n_offers = 0, n_taken = 0;
  int n_dist = 0, n_dist_won = 0, n_results = 0, n_mismatch = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("FAIL best_subtarget_selector");
    $finish;
  end

  // squared distance of the extrapolated position to the target
  function automatic longint dist_sq(subtarget_t s);
    logic signed [18:0] dx, dy;
    longint lx, ly;
    dx = s.x + (s.vx >>> 1) - tgt_x;
    dy = s.y + (s.vy >>> 1) - tgt_y;
    lx = dx;
    ly = dy;
    return lx * lx + ly * ly;
  endfunction

  // sqrt(dc) + m < sqrt(db), exact on integers
  function automatic logic gains_enough(longint dc, longint db, longint m);
    longint m2, t;
    logic [127:0] lhs, rhs;
    m2 = m * m;
    if (db <= dc || db - dc <= m2) return 1'b0;
    t = db - dc - m2;
    if (t >= (longint'(1) << 32)) return 1'b1;
    lhs = t * t;
    rhs = 4 * m2 * dc;
    return lhs > rhs;
  endfunction

  function automatic sel_result_t select_best(word_t w);
    sel_result_t r;
    logic take;
    take = 1'b0;
    if (w.op == OP_LOAD) begin
      take = 1'b1;
      n_loads++;
    end else begin
      n_offers++;
      if (w.c.clear) begin
        w.c.age = '0;
        if (best_now.clear && best_now.eta > eta_limit) begin
          n_dist++;
          take = (w.c.viol <= best_now.viol) &&
                 gains_enough(dist_sq(w.c), dist_sq(best_now), longint'(improve_mm));
          if (take) n_dist_won++;
        end else begin
          take = 1'b1;
        end
      end
    end
    if (take) begin
      best_now = w.c;
      n_taken++;
    end
    r.replaced = take;
    r.best = best_now;
    return r;
  endfunction

  function automatic word_t make_word(logic op, int x, int y, int vx, int vy, int eta,
                                      int viol, logic clr, int age);
    word_t w;
    w.op = op;
    w.c.x = PosW'(x);
    w.c.y = PosW'(y);
    w.c.vx = VelW'(vx);
    w.c.vy = VelW'(vy);
    w.c.eta = EtaW'(eta);
    w.c.viol = ViolW'(viol);
    w.c.clear = clr;
    w.c.age = AgeW'(age);
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.op = ($urandom_range(99) < 20) ? OP_LOAD : OP_OFFER;
    w.c.clear = ($urandom_range(99) < 85);
    if ($urandom_range(1) == 0) begin
      w.c.x = PosW'($urandom);
      w.c.y = PosW'($urandom);
    end else begin
      w.c.x = tgt_x + PosW'($urandom_range(8191)) - PosW'(4096);
      w.c.y = tgt_y + PosW'($urandom_range(8191)) - PosW'(4096);
    end
    if ($urandom_range(1) == 0) begin
      w.c.vx = VelW'($urandom);
      w.c.vy = VelW'($urandom);
    end else begin
      w.c.vx = VelW'($urandom_range(63)) - VelW'(32);
      w.c.vy = VelW'($urandom_range(63)) - VelW'(32);
    end
    w.c.eta = ($urandom_range(99) < 30) ? eta_limit + EtaW'($urandom_range(2)) - EtaW'(1)
                                         : EtaW'($urandom);
    w.c.viol = $urandom_range(1) ? ViolW'($urandom) : ViolW'($urandom_range(3));
    w.c.age = AgeW'($urandom);
    return w;
  endfunction

  function automatic void queue_word(word_t w);
    word_q = {word_q, w};
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TARGET_X:   tgt_x = val;
      REG_TARGET_Y:   tgt_y = val;
      REG_ETA_MARGIN: eta_limit = val;
      REG_IMPROVE:    improve_mm = val[ImpW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_idle(int s, int r);
    @(negedge clk);
    send_idle_pct = s;
    recv_idle_pct = r;
  endtask

  task automatic fill_random(int n);
    @(negedge clk);
    repeat (n) queue_word(rand_word());
  endtask

  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || sel_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic note_error(string what, logic [31:0] exp_v, logic [31:0] got_v);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch at result %0d: %s expected %h got %h", n_results, what, exp_v, got_v);
  endtask

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) note_error(what, exp_v, got_v);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sel_exp_q = {sel_exp_q, select_best(word_on_bus)};
        n_words++;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          word_on_bus = word_q.pop_front();
          in_valid <= 1'b1;
          in_op <= word_on_bus.op;
          in_cand_x <= word_on_bus.c.x;
          in_cand_y <= word_on_bus.c.y;
          in_cand_vx <= word_on_bus.c.vx;
          in_cand_vy <= word_on_bus.c.vy;
          in_cand_eta <= word_on_bus.c.eta;
          in_cand_violations <= word_on_bus.c.viol;
          in_cand_clear <= word_on_bus.c.clear;
          in_cand_age <= word_on_bus.c.age;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sel_exp_q.size() == 0) begin
          note_error("unexpected word, replaced", 32'h0, 32'(out_replaced));
        end else begin
          want = sel_exp_q.pop_front();
          check_field("replaced", want.replaced, out_replaced);
          check_field("best_x", want.best.x, out_best_x_out);
          check_field("best_y", want.best.y, out_best_y_out);
          check_field("best_vx", want.best.vx, out_best_vx_out);
          check_field("best_vy", want.best.vy, out_best_vy_out);
          check_field("best_eta", want.best.eta, out_best_eta_out);
          check_field("best_violations", want.best.viol, out_best_violations_out);
          check_field("best_clear", want.best.clear, out_best_clear_out);
          check_field("best_age", want.best.age, out_best_age_out);
        end
        n_results++;
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the block backs up and stalls its input
  initial begin
    wait (hold_kick);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    best_now = '{default: '0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(27, 51);

    // reset settings: target at origin, margin 500, improvement 500
    @(negedge clk);
    queue_word(make_word(OP_OFFER, 123, 0, 0, 0, 0, 0, 1'b0, 0));
    queue_word(make_word(OP_LOAD, 32767, -32768, 16383, -16384, 65535, 255, 1'b0,
                         65535));
    queue_word(make_word(OP_OFFER, -32768, 32767, -16384, 16383, 0, 0, 1'b1, 65535));
    queue_word(make_word(OP_LOAD, 10000, 0, 0, 0, 500, 5, 1'b1, 7));
    queue_word(make_word(OP_OFFER, 20000, 0, 0, 0, 1, 9, 1'b1, 3));
    queue_word(make_word(OP_LOAD, 10000, 0, 0, 0, 501, 5, 1'b1, 7));
    queue_word(make_word(OP_OFFER, 9500, 0, 0, 0, 600, 5, 1'b1, 3));
    queue_word(make_word(OP_OFFER, 9499, 0, 0, 0, 600, 6, 1'b1, 3));
    queue_word(make_word(OP_OFFER, 9499, 0, 0, 0, 600, 5, 1'b1, 3));
    queue_word(make_word(OP_LOAD, 10000, 0, 0, 0, 501, 5, 1'b1, 7));
    queue_word(make_word(OP_OFFER, 9600, 0, -201, 0, 700, 0, 1'b1, 3));
    queue_word(make_word(OP_LOAD, 10000, 0, 0, 0, 501, 5, 1'b1, 7));
    queue_word(make_word(OP_OFFER, 9600, 0, -199, 0, 700, 0, 1'b1, 3));
    queue_word(make_word(OP_OFFER, 9499, 0, 0, 0, 700, 0, 1'b0, 3));
    queue_word(make_word(OP_LOAD, -32768, -32768, -16384, -16384, 65535, 255, 1'b1, 1));
    queue_word(make_word(OP_OFFER, 32767, 32767, 16383, 16383, 65535, 255, 1'b1, 2));
    queue_word(make_word(OP_OFFER, 0, 0, 0, 0, 900, 255, 1'b1, 2));
    queue_word(make_word(OP_LOAD, 0, -8000, 0, 0, 1000, 0, 1'b1, 9));
    queue_word(make_word(OP_OFFER, 0, -7000, 0, 0, 1000, 0, 1'b1, 9));
    fill_random(150);
    drain();

    // far corner target, no eta margin, widest improvement
    write_reg(REG_TARGET_X, 16'h7FFF);
    write_reg(REG_TARGET_Y, 16'h8000);
    write_reg(REG_ETA_MARGIN, 16'h0000);
    write_reg(REG_IMPROVE, 16'hFFFF);
    fill_random(200);
    hold_kick = 1'b1;
    drain();

    set_idle(51, 27);
    // largest margin: every clear offer replaces
    write_reg(REG_TARGET_X, 16'h8000);
    write_reg(REG_TARGET_Y, 16'h7FFF);
    write_reg(REG_ETA_MARGIN, 16'hFFFF);
    write_reg(REG_IMPROVE, 16'h0000);
    fill_random(150);
    drain();

    // zero improvement: strict distance comparison
    write_reg(REG_TARGET_X, CfgW'(1000));
    write_reg(REG_TARGET_Y, CfgW'(-1000));
    write_reg(REG_ETA_MARGIN, 16'h0000);
    write_reg(REG_IMPROVE, 16'h0000);
    @(negedge clk);
    queue_word(make_word(OP_LOAD, 1300, -1000, 0, 0, 1, 0, 1'b1, 4));
    queue_word(make_word(OP_OFFER, 1000, -1300, 0, 0, 1, 0, 1'b1, 4));
    queue_word(make_word(OP_OFFER, 1299, -1000, 0, 0, 1, 0, 1'b1, 4));
    queue_word(make_word(OP_LOAD, 1000, -1000, 0, 0, 0, 0, 1'b1, 4));
    queue_word(make_word(OP_OFFER, -30000, 30000, 0, 0, 5, 200, 1'b1, 4));
    fill_random(200);
    drain();

    set_idle(0, 0);
    write_reg(REG_TARGET_X, CfgW'($urandom));
    write_reg(REG_TARGET_Y, CfgW'($urandom));
    write_reg(REG_ETA_MARGIN, CfgW'($urandom_range(2000)));
    write_reg(REG_IMPROVE, CfgW'($urandom_range(1000)));
    fill_random(250);
    drain();

    write_reg(REG_TARGET_X, CfgW'($urandom));
    write_reg(REG_TARGET_Y, CfgW'($urandom));
    write_reg(REG_ETA_MARGIN, CfgW'($urandom));
    write_reg(REG_IMPROVE, CfgW'($urandom));
    fill_random(250);
    drain();

    $display("Covered %0d words (%0d loads, %0d offers) over six register settings, %0d replaced",
             n_words, n_loads, n_offers, n_taken);
    $display("%0d offers faced the distance test and %0d won it; %0d mismatches",
             n_dist, n_dist_won, n_mismatch);
    if (n_mismatch == 0 && sel_exp_q.size() == 0)
      $display("PASS best_subtarget_selector");
    else
      $display("FAIL best_subtarget_selector");
    $finish;
  end

endmodule
